@@ design/assert_macros.svh @@
// assertion macros shared by the firing unit modules
// expects signals clk and arst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tpaf_pkg.sv @@
// types and constants of the triac phase-angle firing unit
// no dependencies
package tpaf_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned GATE_W  = 3;
	localparam int unsigned TEMP_W  = 8;
	localparam int unsigned CFG_W   = 8;

	localparam logic [TICK_W-1:0]  DELAY_BASE = 16'd56500;
	localparam logic [TICK_W-1:0]  DELAY_STEP = 16'd90;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 7'd100;
	localparam logic [TEMP_W-1:0]  TEMP_LIMIT_RST = 8'hFF;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_CROSS  = 2'd1,
		CMD_TEMP   = 2'd2,
		CMD_SIGNAL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_DELAY = 2'd1,
		PH_PULSE = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		REG_POWER_PCT   = 2'd0,
		REG_GATE_MASK   = 2'd1,
		REG_TEMP_LIMIT  = 2'd2,
		REG_SYNC_MODE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] power_pct;
		logic [GATE_W-1:0]  gate_enable_mask;
		logic [TEMP_W-1:0]  temp_alarm_limit;
		logic               sync_mode;
	} cfg_t;

	typedef struct packed {
		cmd_t              command;
		logic [TEMP_W-1:0] temp_sample;
		logic              signal_present;
	} item_t;

	typedef struct packed {
		logic [GATE_W-1:0] gate_drive;
		phase_t            firing_phase;
		logic              temp_ok;
		logic              cross_accepted;
	} res_t;

endpackage

@@ design/triac_phase_angle_firing_unit.sv @@
// top level of the triac phase-angle firing unit
// depends on tpaf_pkg, tpaf_cfg_regs, tpaf_ctrl, tpaf_out_reg
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser command, tdata sample and signal
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata gates, phase, temp ok, cross
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// one beat per clock while the output is not stalled
// a beat passes the input register, the state update and then the result register
// reset clears the state and both stage valids and loads the configuration reset values
// a stalled output holds the result register and backs up through the input register

module triac_phase_angle_firing_unit
	import tpaf_pkg::*;
#(
	parameter int unsigned PULSE_RELOAD = 65527
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [15:0]      s_axis_tdata,  // temp_sample[7:0], signal_present[8], unused
	input  logic [1:0]       s_axis_tuser,  // command[1:0]
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // gate_drive[2:0], firing_phase[4:3],
	                                        // temp_ok[5], cross_accepted[6], zero
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t in_item;
	res_t  res;
	res_t  out_res;
	logic  res_valid;
	logic  res_ready;

	assign in_item.command        = cmd_t'(s_axis_tuser);
	assign in_item.temp_sample    = s_axis_tdata[TEMP_W-1:0];
	assign in_item.signal_present = s_axis_tdata[TEMP_W];

	tpaf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (reg_idx_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tpaf_ctrl #(
		.PULSE_RELOAD (PULSE_RELOAD)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	tpaf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {1'b0, out_res.cross_accepted, out_res.temp_ok,
		out_res.firing_phase, out_res.gate_drive};

endmodule

@@ design/tpaf_cfg_regs.sv @@
// configuration register file of the firing unit
// depends on tpaf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tpaf_cfg_regs
	import tpaf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  reg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign cfg_ready = 1'b1;
	assign wr_en     = cfg_valid & cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.power_pct        <= '0;
			cfg_q.gate_enable_mask <= '0;
			cfg_q.temp_alarm_limit <= TEMP_LIMIT_RST;
			cfg_q.sync_mode        <= 1'b0;
		end else if (wr_en) begin
			unique case (cfg_index)
				REG_POWER_PCT:   cfg_q.power_pct        <= cfg_data[LEVEL_W-1:0];
				REG_GATE_MASK:   cfg_q.gate_enable_mask <= cfg_data[GATE_W-1:0];
				REG_TEMP_LIMIT:  cfg_q.temp_alarm_limit <= cfg_data[TEMP_W-1:0];
				REG_SYNC_MODE:   cfg_q.sync_mode        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	`ASSERT_NEXT(a_power_wr, wr_en && cfg_index == REG_POWER_PCT,
		cfg_q.power_pct == $past(cfg_data[LEVEL_W-1:0]), "power level write lost")
	`ASSERT_NEXT(a_limit_wr, wr_en && cfg_index == REG_TEMP_LIMIT,
		cfg_q.temp_alarm_limit == $past(cfg_data[TEMP_W-1:0]), "alarm limit write lost")

endmodule

@@ design/tpaf_ctrl.sv @@
// input register and firing state update of the firing unit
// depends on tpaf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tpaf_ctrl
	import tpaf_pkg::*;
#(
	parameter int unsigned PULSE_RELOAD = 65527
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	localparam logic [TICK_W-1:0] PULSE_LOAD = TICK_W'(PULSE_RELOAD);

	item_t              item_s1;
	logic               vld_s1;
	logic               fire;

	phase_t             phase_q, phase_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [GATE_W-1:0]  gates_q, gates_d;
	logic               temp_allow_q, temp_allow_d;
	logic               sig_seen_q, sig_seen_d;
	logic               accepted;
	logic [LEVEL_W-1:0] level;
	logic [TICK_W-1:0]  delay_load;

	assign in_ready  = !vld_s1 || res_ready;
	assign fire      = vld_s1 && res_ready;
	assign res_valid = vld_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// delay reload from saturated power level
	assign level      = (cfg.power_pct > LEVEL_MAX) ? LEVEL_MAX : cfg.power_pct;
	assign delay_load = DELAY_BASE + TICK_W'(level) * DELAY_STEP;

	always_comb begin
		phase_d      = phase_q;
		tick_d       = tick_q;
		gates_d      = gates_q;
		temp_allow_d = temp_allow_q;
		sig_seen_d   = sig_seen_q;
		accepted     = 1'b0;
		unique case (item_s1.command)
			CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					tick_d = tick_q + TICK_W'(1);
					if (tick_q == '1) begin
						if (phase_q == PH_DELAY) begin
							if (temp_allow_q) begin
								gates_d = gates_q | cfg.gate_enable_mask;
							end
							tick_d  = PULSE_LOAD;
							phase_d = PH_PULSE;
						end else begin
							gates_d = '0;
							phase_d = PH_IDLE;
						end
					end
				end
			end
			CMD_CROSS: begin
				if (!(cfg.sync_mode && !sig_seen_q)) begin
					accepted = 1'b1;
					tick_d   = delay_load;
					phase_d  = PH_DELAY;
				end
			end
			CMD_TEMP: begin
				temp_allow_d = item_s1.temp_sample < cfg.temp_alarm_limit;
			end
			CMD_SIGNAL: begin
				sig_seen_d = item_s1.signal_present;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			gates_q      <= '0;
			temp_allow_q <= 1'b0;
			sig_seen_q   <= 1'b0;
		end else if (fire) begin
			phase_q      <= phase_d;
			tick_q       <= tick_d;
			gates_q      <= gates_d;
			temp_allow_q <= temp_allow_d;
			sig_seen_q   <= sig_seen_d;
		end
	end

	assign res.gate_drive     = gates_d;
	assign res.firing_phase   = phase_d;
	assign res.temp_ok        = temp_allow_d;
	assign res.cross_accepted = accepted;

	`ASSERT_ALWAYS(a_idle_released, phase_q != PH_IDLE || (gates_q == '0 && tick_q == '0),
		"gates or counter active while idle")
	`ASSERT_ALWAYS(a_delay_range, phase_q != PH_DELAY || tick_q >= DELAY_BASE,
		"delay counter below base load")
	`ASSERT_ALWAYS(a_pulse_range, phase_q != PH_PULSE || tick_q >= PULSE_LOAD,
		"pulse counter below reload")

endmodule

@@ design/tpaf_out_reg.sv @@
// result register of the firing unit, parts the core from the output stream
// depends on tpaf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tpaf_out_reg
	import tpaf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic res_valid,
	output logic res_ready,
	input  res_t res,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	logic vld_s2;
	res_t res_s2;

	assign res_ready = !vld_s2 || out_ready;
	assign out_valid = vld_s2;
	assign out_res   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (res_ready) begin
			vld_s2 <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_s2 <= res;
		end
	end

	`ASSERT_ALWAYS(a_cross_phase, !(vld_s2 && res_s2.cross_accepted) ||
		res_s2.firing_phase == PH_DELAY, "accepted cross without delay phase")

endmodule
